@@ src/gba_pkg.sv @@
package gba_pkg;

  localparam int unsigned CoordW = 6;
  localparam int unsigned GridW  = 7;
  localparam int unsigned StepW  = 24;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [StepW-1:0] StepRst = 24'h01_0000;
  localparam logic [GridW-1:0] GridRst = 7'd64;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_TRACE,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e                opcode;
    logic [5:0]         cell_x;
    logic [5:0]         cell_z;
    logic signed [15:0] wind_east;
    logic signed [15:0] wind_north;
    logic [15:0]        humidity;
    logic [15:0]        cloud_cover;
    logic [15:0]        precip_rate;
    logic [2:0]         precip_kind;
  } in_t;

  typedef struct packed {
    logic [5:0]  source_x;
    logic [5:0]  source_z;
    logic [15:0] out_humidity;
    logic [15:0] out_cloud;
    logic [15:0] out_precip_rate;
    logic [2:0]  out_precip_kind;
  } out_t;

endpackage

@@ src/grid_backtrace_advection.sv @@
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o  | gba_pkg::in_t  (store or query)
// out     | output    | out_valid_o / out_stall_i | gba_pkg::out_t (one per query)
// cfg     | input     | cfg_we_i (no wait)       | cfg_idx_i, cfg_data_i
//
// Store transaction: written straight into both cell memories.
// Query transaction: wind read, multiply, trace + moisture read, output load,
//   in that order; the two dependent single-port memory reads force this sequence.
// Reset (rst_ni, async low) clears control and restores the config defaults;
//   memory contents are undefined until written, no clearing pass.
// out_stall_i holds the result register; a new transaction is taken meanwhile
//   until the next query reaches its output step.
module grid_backtrace_advection #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  gba_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output gba_pkg::out_t                      out_data_o,
  input  logic                               cfg_we_i,
  input  logic [gba_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [gba_pkg::CfgDataW-1:0]       cfg_data_i
);
  import gba_pkg::*;

  localparam int Cells = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Cells);
  localparam logic signed [41:0] HalfQ24 = 42'sd8388608;

  // --- configuration -------------------------------------------------------
  logic [StepW-1:0] step_q;
  logic [GridW-1:0] grid_w_q, grid_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= StepRst;
      grid_w_q <= GridRst;
      grid_h_q <= GridRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP:   step_q   <= cfg_data_i[StepW-1:0];
        CFG_WIDTH:  grid_w_q <= cfg_data_i[GridW-1:0];
        CFG_HEIGHT: grid_h_q <= cfg_data_i[GridW-1:0];
        default: ;
      endcase
    end
  end

  // Grid in use: 0 acts as 1, anything past the memory acts as its edge.
  logic [GridW-1:0] w_used, h_used, w_hi, h_hi;

  always_comb begin
    if (grid_w_q == '0)                   w_used = GridW'(1);
    else if (int'(grid_w_q) > MAX_WIDTH)  w_used = GridW'(MAX_WIDTH);
    else                                  w_used = grid_w_q;
    if (grid_h_q == '0)                   h_used = GridW'(1);
    else if (int'(grid_h_q) > MAX_HEIGHT) h_used = GridW'(MAX_HEIGHT);
    else                                  h_used = grid_h_q;
    w_hi = w_used - GridW'(1);
    h_hi = h_used - GridW'(1);
  end

  // --- sequencer -----------------------------------------------------------
  state_e state_q, state_d;
  logic   in_accept, store_we, wind_re, moist_re, out_load;
  logic   out_valid_q;

  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_accept && in_data_i.opcode == OP_QUERY) state_d = ST_MUL;
      ST_MUL:   state_d = ST_TRACE;
      ST_TRACE: state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    wind_re    = in_accept && in_data_i.opcode == OP_QUERY;
    moist_re   = (state_q == ST_TRACE);
    out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // --- store path: cells outside the memory are dropped ---------------------
  logic [AW-1:0] st_addr;

  assign store_we = in_accept && in_data_i.opcode == OP_STORE &&
                    int'(in_data_i.cell_x) < MAX_WIDTH &&
                    int'(in_data_i.cell_z) < MAX_HEIGHT;
  assign st_addr  = AW'(in_data_i.cell_z) * AW'(MAX_WIDTH) + AW'(in_data_i.cell_x);

  // --- query: clamp to grid, read own wind ----------------------------------
  logic [GridW-1:0] qx_d, qz_d, qx_q, qz_q;
  logic [AW-1:0]    q_addr;

  always_comb begin
    qx_d = ({1'b0, in_data_i.cell_x} > w_hi) ? w_hi : {1'b0, in_data_i.cell_x};
    qz_d = ({1'b0, in_data_i.cell_z} > h_hi) ? h_hi : {1'b0, in_data_i.cell_z};
  end
  assign q_addr = AW'(qz_d) * AW'(MAX_WIDTH) + AW'(qx_d);

  always_ff @(posedge clk_i) begin
    if (wind_re) begin
      qx_q <= qx_d;
      qz_q <= qz_d;
    end
  end

  // Accesses never overlap: stores only land in ST_IDLE, and both reads of a
  // query finish before the next transaction is taken.
  logic [31:0] wind_mem [Cells];
  logic [31:0] wind_rd_q;

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      wind_mem[st_addr] <= {in_data_i.wind_east, in_data_i.wind_north};
    end
    if (wind_re) begin
      wind_rd_q <= wind_mem[q_addr];
    end
  end

  // --- multiply: wind Q8.8 x scale Q8.16 -> Q16.24 --------------------------
  logic signed [40:0] prod_e_q, prod_n_q;
  logic signed [24:0] scale_s;

  assign scale_s = $signed({1'b0, step_q});

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_e_q <= 41'($signed(wind_rd_q[31:16])) * 41'(scale_s);
      prod_n_q <= 41'($signed(wind_rd_q[15:0])) * 41'(scale_s);
    end
  end

  // --- trace back, round half up, clamp ------------------------------------
  function automatic logic [GridW-1:0] trace_src(input logic [GridW-1:0]  pos,
                                                 input logic signed [40:0] prod,
                                                 input logic [GridW-1:0]  hi);
    logic signed [41:0] back;
    logic signed [17:0] fl;
    back = $signed({11'd0, pos, 24'd0}) - $signed({prod[40], prod}) + HalfQ24;
    fl   = back[41:24];
    if (fl[17])                          return '0;
    else if (fl > $signed({11'd0, hi}))  return hi;
    else                                 return fl[GridW-1:0];
  endfunction

  logic [GridW-1:0] sx_d, sz_d, sx_q, sz_q;
  logic [AW-1:0]    s_addr;

  assign sx_d   = trace_src(qx_q, prod_e_q, w_hi);
  assign sz_d   = trace_src(qz_q, prod_n_q, h_hi);
  assign s_addr = AW'(sz_d) * AW'(MAX_WIDTH) + AW'(sx_d);

  always_ff @(posedge clk_i) begin
    if (moist_re) begin
      sx_q <= sx_d;
      sz_q <= sz_d;
    end
  end

  // moisture word: humidity, cloud, rate, kind
  logic [50:0] moist_mem [Cells];
  logic [50:0] moist_rd_q;

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      moist_mem[st_addr] <= {in_data_i.humidity, in_data_i.cloud_cover,
                             in_data_i.precip_rate, in_data_i.precip_kind};
    end
    if (moist_re) begin
      moist_rd_q <= moist_mem[s_addr];
    end
  end

  // --- result register ------------------------------------------------------
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.source_x        <= sx_q[CoordW-1:0];
      out_q.source_z        <= sz_q[CoordW-1:0];
      out_q.out_humidity    <= moist_rd_q[50:35];
      out_q.out_cloud       <= moist_rd_q[34:19];
      out_q.out_precip_rate <= moist_rd_q[18:3];
      out_q.out_precip_kind <= moist_rd_q[2:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/gba_checker.sv @@
module gba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input gba_pkg::in_t                 in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input gba_pkg::out_t                out_data_o,
  input logic                         cfg_we_i,
  input logic [gba_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [gba_pkg::CfgDataW-1:0] cfg_data_i
);
  import gba_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a query busies the input side while it walks the memories
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.opcode == OP_QUERY |=> in_stall_o)
    else $error("query did not hold off the input");

  // a store leaves the input free and produces no result
  a_store_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.opcode == OP_STORE |=> !in_stall_o && !$rose(out_valid_o))
    else $error("store stalled input or produced a result");

  // the result cannot appear before both memory reads are done
  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.opcode == OP_QUERY |=> !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("result came out too early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // register writes are to land only while no query is in progress; the block does not enforce it
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_stall_o && !$isunknown({cfg_idx_i, cfg_data_i}))
    else $error("register write during a query");

endmodule

bind grid_backtrace_advection gba_checker u_gba_checker (.*);
